/* rtl/tmwf_pkg.sv */
// Shared types and constants for the trimmed mean weight filter.
package tmwf_pkg;

  localparam int SAMPLE_W = 24;
  localparam int WLEN_W   = 8;
  localparam int SCALE_W  = 34;
  localparam int WEIGHT_W = 42;
  localparam int USED_W   = 6;
  localparam int CIDX_W   = 2;
  localparam int MIN_WIN  = 5;
  localparam int TRIM_SH  = 2;   // quarter trim: n >> 2
  localparam int SCL_LO_W = 17;  // low part of scale in the first partial product

  localparam logic [CIDX_W-1:0] REG_WINDOW_LEN  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_ZERO_OFFSET = 2'd1;
  localparam logic [CIDX_W-1:0] REG_SCALE_RECIP = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_TAIL, S_SHIFT, S_DINIT, S_DIV, S_DIFF, S_MUL_LO, S_MUL_HI, S_DONE
  } tmwf_state_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic shift;
    logic div_init;
    logic div_step;
    logic diff;
    logic mul_lo;
    logic mul_hi;
    logic out_load;
  } tmwf_cmd_t;

  typedef struct packed {
    logic load_last;
    logic shift_last;
    logic div_last;
    logic out_busy;
  } tmwf_sts_t;

endpackage

/* rtl/tmwf_ctrl.sv */
// Sequencer that steps the datapath through load, sort, sum, divide and scale.
module tmwf_ctrl
  import tmwf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  tmwf_sts_t   sts,
  output tmwf_cmd_t   cmd
);

  tmwf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_LOAD;
      S_LOAD:   if (sts.load_last) state_nxt = S_TAIL;
      S_TAIL:   state_nxt = S_SHIFT;
      S_SHIFT:  if (sts.shift_last) state_nxt = S_DINIT;
      S_DINIT:  state_nxt = S_DIV;
      S_DIV:    if (sts.div_last) state_nxt = S_DIFF;
      S_DIFF:   state_nxt = S_MUL_LO;
      S_MUL_LO: state_nxt = S_MUL_HI;
      S_MUL_HI: state_nxt = S_DONE;
      S_DONE:   if (!sts.out_busy) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_LOAD:   cmd.issue    = 1'b1;
      S_TAIL:   cmd          = '0;
      S_SHIFT:  cmd.shift    = 1'b1;
      S_DINIT:  cmd.div_init = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_DIFF:   cmd.diff     = 1'b1;
      S_MUL_LO: cmd.mul_lo   = 1'b1;
      S_MUL_HI: cmd.mul_hi   = 1'b1;
      S_DONE:   cmd.out_load = !sts.out_busy;
      default:  cmd          = '0;
    endcase
  end

endmodule

/* rtl/tmwf_dp.sv */
// Datapath: sample ring, insertion sorter, trimmed sum, divider, scaling and output register.
module tmwf_dp
  import tmwf_pkg::*;
#(
  parameter int RING_DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tmwf_cmd_t                  cmd,
  output tmwf_sts_t                  sts,
  input  logic                       cfg_we,
  input  logic [CIDX_W-1:0]          cfg_idx,
  input  logic [SCALE_W-1:0]         cfg_wdata,
  input  logic signed [SAMPLE_W-1:0] in_raw_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [WEIGHT_W-1:0] out_weight_q16,
  output logic [USED_W-1:0]          out_samples_used
);

  localparam int PW  = $clog2(RING_DEPTH);
  localparam int NW  = $clog2(RING_DEPTH + 1);
  localparam int SW  = SAMPLE_W + NW;
  localparam int DCW = $clog2(SW);
  localparam int DW  = SAMPLE_W + 1;
  localparam int PW2 = 2 * SAMPLE_W + 11; // full product width
  localparam logic [8:0] DEP9 = 9'(RING_DEPTH);
  localparam logic [8:0] MIN9 = 9'(MIN_WIN);

  // configuration
  logic [WLEN_W-1:0]          wlen_r;
  logic signed [SAMPLE_W-1:0] zoff_r;
  logic signed [SCALE_W-1:0]  scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= WLEN_W'(10);
      zoff_r  <= '0;
      scale_r <= SCALE_W'(64'sd4294967296);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WINDOW_LEN:  wlen_r  <= cfg_wdata[WLEN_W-1:0];
        REG_ZERO_OFFSET: zoff_r  <= cfg_wdata[SAMPLE_W-1:0];
        REG_SCALE_RECIP: scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ring and bookkeeping
  logic signed [SAMPLE_W-1:0] ring [RING_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [NW-1:0] cnt_r, cnt_new, n_r, iss_r, k_r, pos_r;
  logic [8:0]    n0, n1, n2;
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic          rd_vld_r;

  assign cnt_new = (cnt_r == NW'(RING_DEPTH)) ? cnt_r : cnt_r + NW'(1);

  always_comb begin
    n0 = (9'(wlen_r) < MIN9) ? MIN9 : 9'(wlen_r);
    n1 = (n0 > DEP9) ? DEP9 : n0;
    n2 = (n1 > 9'(cnt_new)) ? 9'(cnt_new) : n1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cmd.accept) begin
        wp_r  <= (wp_r == PW'(RING_DEPTH - 1)) ? '0 : wp_r + PW'(1);
        cnt_r <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring[wp_r] <= in_raw_sample;
      rp_r       <= wp_r;
      n_r        <= n2[NW-1:0];
      iss_r      <= '0;
      k_r        <= '0;
    end
    if (cmd.issue) begin
      rd_data_r <= ring[rp_r];
      rp_r      <= (rp_r == '0) ? PW'(RING_DEPTH - 1) : rp_r - PW'(1);
      iss_r     <= iss_r + NW'(1);
    end
    if (rd_vld_r) begin
      k_r <= k_r + NW'(1);
    end
  end

  // insertion sorter: each cell decides on its own from its neighbor
  logic signed [SAMPLE_W-1:0] s_r   [RING_DEPTH];
  logic signed [SAMPLE_W-1:0] s_nxt [RING_DEPTH];
  logic [RING_DEPTH-1:0]      gt;

  always_comb begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      gt[i] = (NW'(i) >= k_r) || (s_r[i] > rd_data_r);
    end
    for (int i = 0; i < RING_DEPTH; i++) begin
      if (cmd.shift) begin
        s_nxt[i] = (i == RING_DEPTH - 1) ? s_r[i] : s_r[(i + 1) % RING_DEPTH];
      end else if (rd_vld_r && gt[i]) begin
        if (i == 0) begin
          s_nxt[i] = rd_data_r;
        end else begin
          s_nxt[i] = gt[(i + RING_DEPTH - 1) % RING_DEPTH] ?
                     s_r[(i + RING_DEPTH - 1) % RING_DEPTH] : rd_data_r;
        end
      end else begin
        s_nxt[i] = s_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      s_r[i] <= s_nxt[i];
    end
  end

  // trimmed sum while shifting the sorted window out of cell zero
  logic [NW-1:0]        lo, hi, m;
  logic signed [SW-1:0] sum_r;
  assign lo = n_r >> TRIM_SH;
  assign hi = n_r - lo;
  assign m  = hi - lo;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sum_r <= '0;
      pos_r <= '0;
    end else if (cmd.shift) begin
      pos_r <= pos_r + NW'(1);
      if (pos_r >= lo && pos_r < hi) begin
        sum_r <= sum_r + SW'(s_r[0]);
      end
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [SW-1:0]  dq_r;
  logic [NW:0]    rem_r, trial;
  logic [NW+1:0]  tsub;
  logic           neg_r;
  logic [DCW-1:0] dcnt_r;

  assign trial = {rem_r[NW-1:0], dq_r[SW-1]};
  assign tsub  = {1'b0, trial} - {2'b00, m};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg_r  <= sum_r[SW-1];
      dq_r   <= sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + DCW'(1);
      if (!tsub[NW+1]) begin
        rem_r <= tsub[NW:0];
        dq_r  <= {dq_r[SW-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        dq_r  <= {dq_r[SW-2:0], 1'b0};
      end
    end
  end

  // offset, two partial products, output register
  logic signed [DW-1:0]          diff_r, avg;
  logic signed [DW+SCL_LO_W:0]   plo_r;
  logic signed [DW+SCALE_W-SCL_LO_W-1:0] phi_r;
  logic signed [PW2-1:0]         prod;
  logic                          out_valid_r;
  logic signed [WEIGHT_W-1:0]    weight_r;
  logic [USED_W-1:0]             used_r;

  assign avg  = neg_r ? -$signed(dq_r[DW-1:0]) : $signed(dq_r[DW-1:0]);
  assign prod = (PW2'(phi_r) <<< SCL_LO_W) + PW2'(plo_r);

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      diff_r <= avg - DW'(zoff_r);
    end
    if (cmd.mul_lo) begin
      plo_r <= diff_r * $signed({1'b0, scale_r[SCL_LO_W-1:0]});
    end
    if (cmd.mul_hi) begin
      phi_r <= diff_r * $signed(scale_r[SCALE_W-1:SCL_LO_W]);
    end
    if (cmd.out_load) begin
      weight_r <= prod[WEIGHT_W+15:16];
      used_r   <= USED_W'(n_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.load_last  = (iss_r == n_r - NW'(1));
  assign sts.shift_last = (pos_r == n_r - NW'(1));
  assign sts.div_last   = (dcnt_r == DCW'(SW - 1));
  assign sts.out_busy   = out_valid_r && out_stall;

  assign out_valid        = out_valid_r;
  assign out_weight_q16   = weight_r;
  assign out_samples_used = used_r;

endmodule

/* rtl/trimmed_mean_weight_filter.sv */
// Trimmed mean load-cell filter: one sample in, one Q26.16 weight out, one item at a time.
// Each sample goes into a ring of RING_DEPTH entries; the newest n samples (window_len
// clamped to 5..RING_DEPTH and to the samples held) are read one a cycle into an insertion
// sorter, shifted out one a cycle while the middle half is summed, divided by a restoring
// divider at one bit a cycle, offset and scaled with a 25x18 and a 25x17 partial product. The
// time from accept to the next accept is set by the ring read port, the sorter shift-out
// and the divider; in_stall is low only while the block is idle, and a result still
// stalled at the end of an item adds its stall time.
module trimmed_mean_weight_filter
  import tmwf_pkg::*;
#(
  parameter int RING_DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CIDX_W-1:0]          cfg_idx,
  input  logic [SCALE_W-1:0]         cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_raw_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [WEIGHT_W-1:0] out_weight_q16,
  output logic [USED_W-1:0]          out_samples_used
);

  tmwf_cmd_t cmd;
  tmwf_sts_t sts;

  tmwf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tmwf_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .in_raw_sample    (in_raw_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_weight_q16   (out_weight_q16),
    .out_samples_used (out_samples_used)
  );

endmodule

/* rtl/tmwf_chk.sv */
// Port-level checks for the trimmed mean weight filter, bound to the top level.
module tmwf_chk
  import tmwf_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [WEIGHT_W-1:0] out_weight_q16,
  input logic [USED_W-1:0]          out_samples_used
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // one transaction at a time: busy right after accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // results appear only from a busy block
  a_rose: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work");

  // hold the payload of a stalled result
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_weight_q16) && $stable(out_samples_used))
    else $error("stalled result changed");

endmodule

bind trimmed_mean_weight_filter tmwf_chk u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_weight_q16   (out_weight_q16),
  .out_samples_used (out_samples_used)
);
